FILE: src/ckuq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckuq_pkg: shared types and constants of the coalescing keyed update queue
// Word layouts, request and status codes, sizes and the controller states.
// ----------------------------------------------------------------------------
package ckuq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int MAX_BATCH   = 16;
    localparam int BATCH_W     = 5;
    localparam int DYN_BIT     = 63;

    localparam logic [BATCH_W-1:0] BATCH_CAP = BATCH_W'(MAX_BATCH);

    localparam logic [1:0] REQ_UPSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_POP    = 2'd2;
    localparam logic [1:0] REQ_CLEAR  = 2'd3;

    localparam logic KIND_UPSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    localparam logic [3:0] STS_NEW      = 4'd0;
    localparam logic [3:0] STS_REPLACED = 4'd1;
    localparam logic [3:0] STS_IGNORED  = 4'd2;
    localparam logic [3:0] STS_ZERO     = 4'd3;
    localparam logic [3:0] STS_NOT_DYN  = 4'd4;
    localparam logic [3:0] STS_FULL     = 4'd5;
    localparam logic [3:0] STS_POPPED   = 4'd6;
    localparam logic [3:0] STS_EMPTY    = 4'd7;
    localparam logic [3:0] STS_CLEARED  = 4'd8;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [63:0]        entity_id;
        logic [63:0]        revision;
        logic [31:0]        zone_id;
        logic [15:0]        payload_ref;
        logic [BATCH_W-1:0] batch_limit;
    } cmd_t;

    typedef struct packed {
        logic [3:0]  status;
        logic        out_kind;
        logic [63:0] out_entity_id;
        logic [63:0] out_revision;
        logic [31:0] out_zone_id;
        logic [15:0] out_payload_ref;
        logic        last;
    } res_t;

    typedef struct packed {
        logic        kind;
        logic [63:0] key;
        logic [63:0] revision;
        logic [31:0] zone;
        logic [15:0] payload;
    } slot_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MERGE,
        S_INSERT,
        S_RESP,
        S_POP_RING,
        S_POP_SLOT,
        S_POP_OUT
    } state_t;

endpackage

FILE: src/ckuq_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckuq_ram: simple dual-port RAM
// One write port, one read port, read data registered and held until the
// next read.
// ----------------------------------------------------------------------------
module ckuq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: src/coalescing_keyed_update_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coalescing_keyed_update_queue: keyed queue of pending update/remove words
// Entries live in a slot RAM, arrival order in a ring RAM of slot indexes.
// ----------------------------------------------------------------------------
// One command word is taken at a time. An upsert or remove that passes the
// id checks walks the slot RAM through its single read port, one slot per
// cycle, until it finds the id or has seen every slot; a new id is then
// inserted unless the table is full. A command that fails the id checks,
// a clear or an empty pop is answered with a single result without a scan.
// A pop returns each entry by a ring read, a slot read and an output step.
// Results leave through an output register, and the next command is taken
// as soon as the last result of the previous one is loaded there.
module coalescing_keyed_update_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_stall,
    input  ckuq_pkg::cmd_t   cmd,
    output logic             res_valid,
    input  logic             res_stall,
    output ckuq_pkg::res_t   res
);

    localparam int DEPTH  = ckuq_pkg::QUEUE_DEPTH;
    localparam int IDX_W  = ckuq_pkg::IDX_W;
    localparam int CNT_W  = ckuq_pkg::CNT_W;
    localparam int BW     = ckuq_pkg::BATCH_W;
    localparam int SLOT_W = $bits(ckuq_pkg::slot_t);

    ckuq_pkg::state_t     state_reg, state_next;
    ckuq_pkg::cmd_t       item_reg, item_next;
    logic [3:0]           status_reg, status_next;
    logic [CNT_W-1:0]     scan_cnt_reg, scan_cnt_next;
    logic                 cmp_pend_reg, cmp_pend_next;
    logic [IDX_W-1:0]     cmp_idx_reg, cmp_idx_next;
    logic [IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic                 hit_kind_reg, hit_kind_next;
    logic [63:0]          hit_rev_reg, hit_rev_next;
    logic [DEPTH-1:0]     slot_valid_reg, slot_valid_next;
    logic [IDX_W-1:0]     head_reg, head_next;
    logic [IDX_W-1:0]     tail_reg, tail_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [BW-1:0]        limit_reg, limit_next;
    logic [BW-1:0]        popped_reg, popped_next;
    logic [IDX_W-1:0]     pop_idx_reg, pop_idx_next;
    logic                 res_valid_reg, res_valid_next;
    ckuq_pkg::res_t       res_reg, res_next;

    logic                 accept;
    logic                 res_free;
    logic                 cmd_zero;
    logic                 cmd_not_dyn;
    logic                 hit;
    logic                 scan_done;
    logic                 pop_last;
    logic [IDX_W-1:0]     free_idx;
    logic [BW-1:0]        limit_clamped;
    ckuq_pkg::slot_t      new_slot;

    logic                 slot_we, slot_re;
    logic [IDX_W-1:0]     slot_waddr, slot_raddr;
    ckuq_pkg::slot_t      slot_rdata;
    logic                 ring_we, ring_re;
    logic [IDX_W-1:0]     ring_rdata;

    // ------------------------------------------------------------------
    // storage
    // ------------------------------------------------------------------
    ckuq_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (DEPTH)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (new_slot),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    ckuq_ram #(
        .WIDTH (IDX_W),
        .DEPTH (DEPTH)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (tail_reg),
        .wdata (free_idx),
        .re    (ring_re),
        .raddr (head_reg),
        .rdata (ring_rdata)
    );

    // ------------------------------------------------------------------
    // shared decode
    // ------------------------------------------------------------------
    assign accept      = cmd_valid && !cmd_stall;
    assign res_free    = !res_valid_reg || !res_stall;
    assign cmd_zero    = (cmd.entity_id == 64'd0)
                      || (cmd.req_type == ckuq_pkg::REQ_UPSERT && cmd.zone_id == 32'd0);
    assign cmd_not_dyn = !cmd.entity_id[ckuq_pkg::DYN_BIT];
    assign hit         = cmp_pend_reg && slot_valid_reg[cmp_idx_reg]
                      && (slot_rdata.key == item_reg.entity_id);
    assign scan_done   = (scan_cnt_reg == CNT_W'(DEPTH));
    assign pop_last    = ((popped_reg + 1'b1) == limit_reg) || (count_reg == CNT_W'(1));

    always_comb
    begin
        if (cmd.batch_limit == '0)
        begin
            limit_clamped = BW'(1);
        end
        else if (cmd.batch_limit > ckuq_pkg::BATCH_CAP)
        begin
            limit_clamped = ckuq_pkg::BATCH_CAP;
        end
        else
        begin
            limit_clamped = cmd.batch_limit;
        end
    end

    // lowest free slot
    always_comb
    begin
        free_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (!slot_valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    // a stored remove keeps revision, zone and payload at zero
    always_comb
    begin
        new_slot.kind = item_reg.req_type[0];
        new_slot.key  = item_reg.entity_id;
        if (item_reg.req_type == ckuq_pkg::REQ_REMOVE)
        begin
            new_slot.revision = '0;
            new_slot.zone     = '0;
            new_slot.payload  = '0;
        end
        else
        begin
            new_slot.revision = item_reg.revision;
            new_slot.zone     = item_reg.zone_id;
            new_slot.payload  = item_reg.payload_ref;
        end
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ckuq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    unique case (cmd.req_type)
                        ckuq_pkg::REQ_UPSERT, ckuq_pkg::REQ_REMOVE:
                        begin
                            state_next = (cmd_zero || cmd_not_dyn)
                                       ? ckuq_pkg::S_RESP : ckuq_pkg::S_SCAN;
                        end
                        ckuq_pkg::REQ_POP:
                        begin
                            state_next = (count_reg == '0)
                                       ? ckuq_pkg::S_RESP : ckuq_pkg::S_POP_RING;
                        end
                        default:
                        begin
                            state_next = ckuq_pkg::S_RESP;
                        end
                    endcase
                end
            end
            ckuq_pkg::S_SCAN:
            begin
                priority if (hit)
                begin
                    state_next = ckuq_pkg::S_MERGE;
                end
                else if (scan_done)
                begin
                    state_next = ckuq_pkg::S_INSERT;
                end
            end
            ckuq_pkg::S_MERGE, ckuq_pkg::S_INSERT:
            begin
                state_next = ckuq_pkg::S_RESP;
            end
            ckuq_pkg::S_RESP:
            begin
                if (res_free)
                begin
                    state_next = ckuq_pkg::S_IDLE;
                end
            end
            ckuq_pkg::S_POP_RING:
            begin
                state_next = ckuq_pkg::S_POP_SLOT;
            end
            ckuq_pkg::S_POP_SLOT:
            begin
                state_next = ckuq_pkg::S_POP_OUT;
            end
            ckuq_pkg::S_POP_OUT:
            begin
                if (res_free)
                begin
                    state_next = pop_last ? ckuq_pkg::S_IDLE : ckuq_pkg::S_POP_RING;
                end
            end
            default:
            begin
                state_next = ckuq_pkg::S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // outputs and datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        item_next       = item_reg;
        status_next     = status_reg;
        scan_cnt_next   = scan_cnt_reg;
        cmp_pend_next   = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_kind_next   = hit_kind_reg;
        hit_rev_next    = hit_rev_reg;
        slot_valid_next = slot_valid_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        limit_next      = limit_reg;
        popped_next     = popped_reg;
        pop_idx_next    = pop_idx_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;
        slot_we         = 1'b0;
        slot_re         = 1'b0;
        slot_waddr      = hit_idx_reg;
        slot_raddr      = scan_cnt_reg[IDX_W-1:0];
        ring_we         = 1'b0;
        ring_re         = 1'b0;

        unique case (state_reg)
            ckuq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    item_next     = cmd;
                    scan_cnt_next = '0;
                    popped_next   = '0;
                    limit_next    = limit_clamped;
                    unique case (cmd.req_type)
                        ckuq_pkg::REQ_UPSERT, ckuq_pkg::REQ_REMOVE:
                        begin
                            status_next = cmd_zero ? ckuq_pkg::STS_ZERO
                                                   : ckuq_pkg::STS_NOT_DYN;
                        end
                        ckuq_pkg::REQ_POP:
                        begin
                            status_next = ckuq_pkg::STS_EMPTY;
                        end
                        default:
                        begin
                            status_next     = ckuq_pkg::STS_CLEARED;
                            slot_valid_next = '0;
                            head_next       = '0;
                            tail_next       = '0;
                            count_next      = '0;
                        end
                    endcase
                end
            end
            ckuq_pkg::S_SCAN:
            begin
                // read slot scan_cnt now, compare it next cycle
                if (!scan_done)
                begin
                    slot_re       = 1'b1;
                    cmp_pend_next = 1'b1;
                    cmp_idx_next  = scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_next = scan_cnt_reg + 1'b1;
                end
                hit_idx_next  = cmp_idx_reg;
                hit_kind_next = slot_rdata.kind;
                hit_rev_next  = slot_rdata.revision;
            end
            ckuq_pkg::S_MERGE:
            begin
                priority if (item_reg.req_type == ckuq_pkg::REQ_REMOVE)
                begin
                    slot_we     = 1'b1;
                    status_next = ckuq_pkg::STS_REPLACED;
                end
                else if (hit_kind_reg == ckuq_pkg::KIND_REMOVE)
                begin
                    status_next = ckuq_pkg::STS_IGNORED;
                end
                else if (item_reg.revision >= hit_rev_reg)
                begin
                    slot_we     = 1'b1;
                    status_next = ckuq_pkg::STS_REPLACED;
                end
                else
                begin
                    status_next = ckuq_pkg::STS_IGNORED;
                end
            end
            ckuq_pkg::S_INSERT:
            begin
                if (count_reg == CNT_W'(DEPTH))
                begin
                    status_next = ckuq_pkg::STS_FULL;
                end
                else
                begin
                    slot_we                   = 1'b1;
                    slot_waddr                = free_idx;
                    ring_we                   = 1'b1;
                    slot_valid_next[free_idx] = 1'b1;
                    tail_next  = (tail_reg == IDX_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
                    count_next = count_reg + 1'b1;
                    status_next = ckuq_pkg::STS_NEW;
                end
            end
            ckuq_pkg::S_RESP:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.status = status_reg;
                    res_next.last   = 1'b1;
                end
            end
            ckuq_pkg::S_POP_RING:
            begin
                ring_re = 1'b1;
            end
            ckuq_pkg::S_POP_SLOT:
            begin
                slot_re      = 1'b1;
                slot_raddr   = ring_rdata;
                pop_idx_next = ring_rdata;
            end
            ckuq_pkg::S_POP_OUT:
            begin
                if (res_free)
                begin
                    res_valid_next               = 1'b1;
                    res_next.status              = ckuq_pkg::STS_POPPED;
                    res_next.out_kind            = slot_rdata.kind;
                    res_next.out_entity_id       = slot_rdata.key;
                    res_next.out_revision        = slot_rdata.revision;
                    res_next.out_zone_id         = slot_rdata.zone;
                    res_next.out_payload_ref     = slot_rdata.payload;
                    res_next.last                = pop_last;
                    slot_valid_next[pop_idx_reg] = 1'b0;
                    head_next   = (head_reg == IDX_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                    count_next  = count_reg - 1'b1;
                    popped_next = popped_reg + 1'b1;
                end
            end
            default:
            begin
                slot_re = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ckuq_pkg::S_IDLE;
            cmp_pend_reg   <= 1'b0;
            slot_valid_reg <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmp_pend_reg   <= cmp_pend_next;
            slot_valid_reg <= slot_valid_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        status_reg   <= status_next;
        scan_cnt_reg <= scan_cnt_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_kind_reg <= hit_kind_next;
        hit_rev_reg  <= hit_rev_next;
        limit_reg    <= limit_next;
        popped_reg   <= popped_next;
        pop_idx_reg  <= pop_idx_next;
        res_reg      <= res_next;
    end

    assign cmd_stall = (state_reg != ckuq_pkg::S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

`ifndef SYNTHESIS
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("pending count exceeds queue depth");

    a_empty_no_slots: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (slot_valid_reg == '0))
        else $error("empty queue still holds valid slots");

    a_pop_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ckuq_pkg::S_POP_OUT && res_free) |-> slot_valid_reg[pop_idx_reg])
        else $error("popped slot was not valid");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.status != ckuq_pkg::STS_POPPED) |-> res_reg.last)
        else $error("non-pop result without last marker");
`endif

endmodule
